FILE: hdl/f2d_pkg.sv
package f2d_pkg;

  // Grid geometry
  localparam int GRID_SIZE = 1024;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int EXT_W     = $clog2(GRID_SIZE + 1);   // holds 0..GRID_SIZE
  localparam int ADDR_W    = $clog2(CELLS);

  // Field widths
  localparam int FLD_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 52;

  // Operation codes
  localparam logic OP_SET = 1'b0;
  localparam logic OP_SUM = 1'b1;

  // Quadrant codes of the inclusion-exclusion sum
  localparam logic [1:0] QUAD_LAST = 2'd3;

  typedef logic [EXT_W-1:0]  ext_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SUM_W-1:0]  sum_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_CELL,
    ST_SET_DIFF,
    ST_SET_RD,
    ST_SET_WR,
    ST_SUM_LOAD,
    ST_SUM_WALK,
    ST_SUM_DONE,
    ST_SUM_OUT
  } state_t;

  // Flat address of tree node (r, c), both one-based
  function automatic addr_t addr_of(ext_t r, ext_t c);
    addr_t rr;
    addr_t cc;
    rr = ADDR_W'(r - EXT_W'(1));
    cc = ADDR_W'(c - EXT_W'(1));
    return ADDR_W'(rr * ADDR_W'(GRID_SIZE)) + cc;
  endfunction

  // Prefix extent saturated at the grid size
  function automatic ext_t sat_ext(logic [FLD_W:0] n);
    if (int'(n) > GRID_SIZE) begin
      return EXT_W'(GRID_SIZE);
    end
    return EXT_W'(n);
  endfunction

  // Widen a 32-bit signed value to the tree width
  function automatic sum_t sext(logic [VAL_W-1:0] v);
    return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

endpackage

FILE: hdl/fenwick_2d_set_rect_sum_unit.sv
// Two-dimensional Fenwick tree over a 1024 x 1024 grid of signed 32-bit cells.
// Input channel (in_valid / in_stall): one word per operation. op = set writes
// new_value to cell (row, col) and returns nothing; op = sum returns the total of
// rows row..end_row and columns col..end_col as a 52-bit signed word.
// Output channel (out_valid / out_stall): one rect_sum word per sum.
// The block takes one word at a time; in_stall stays high while it works.
// Set: the cell is read, the difference to new_value formed and the cell rewritten,
//   then every node of row path x column path (at most 11 x 11) is read and written.
// Sum: the four prefix paths (at most 10 x 10 nodes per prefix) are walked in turn,
//   one tree memory read per cycle through the shared adder; ST_SUM_DONE and
//   ST_SUM_OUT follow, and out_valid is registered as ST_SUM_OUT passes to idle.
// After reset both memories are zeroed by a pass over all GRID_SIZE * GRID_SIZE
// entries (1048576), one entry per cycle; in_stall is high during it.
// A finished sum sits in the output register while out_stall is high; the
// block then waits before returning to idle, so no result is dropped.
module fenwick_2d_set_rect_sum_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic        [f2d_pkg::FLD_W-1:0]  in_row,
  input  logic        [f2d_pkg::FLD_W-1:0]  in_col,
  input  logic        [f2d_pkg::FLD_W-1:0]  in_end_row,
  input  logic        [f2d_pkg::FLD_W-1:0]  in_end_col,
  input  logic signed [f2d_pkg::VAL_W-1:0]  in_new_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [f2d_pkg::SUM_W-1:0]  out_rect_sum
);

  localparam f2d_pkg::addr_t CLR_LAST = f2d_pkg::ADDR_W'(f2d_pkg::CELLS - 1);
  localparam logic [f2d_pkg::EXT_W:0] GRID_EXT = (f2d_pkg::EXT_W + 1)'(f2d_pkg::GRID_SIZE);

  f2d_pkg::state_t state_r, state_nxt;

  // latched word
  logic [f2d_pkg::FLD_W-1:0] row_r, col_r, erow_r, ecol_r;
  logic [f2d_pkg::VAL_W-1:0] nv_r;

  // walk state
  logic [1:0]     q_r, q_nxt;
  f2d_pkg::ext_t  r_r, r_nxt, c_r, c_nxt, c0_r, c0_nxt;
  f2d_pkg::sum_t  diff_r, diff_nxt, acc_r, acc_nxt;
  logic           pend_r, pend_nxt, sign_r, sign_nxt;
  f2d_pkg::addr_t clr_r, clr_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  f2d_pkg::sum_t out_sum_r, out_sum_nxt;

  // memory ports
  f2d_pkg::addr_t tree_addr, cell_addr;
  logic           tree_we, cell_we;
  f2d_pkg::sum_t  tree_wdata, tree_rdata;
  logic [f2d_pkg::VAL_W-1:0] cell_wdata, cell_rdata;

  // shared units
  f2d_pkg::sum_t alu_a, alu_b, alu_y;
  logic          alu_sub;
  logic          walk_down;
  logic [f2d_pkg::EXT_W:0] r_step, c_step;

  // quadrant extents
  f2d_pkg::ext_t er, ec, sr, sc, quad_r, quad_c;
  logic          accept, in_grid, out_free, col_end, row_end;

  assign accept   = in_valid && !in_stall;
  assign in_grid  = (int'(in_row) < f2d_pkg::GRID_SIZE) && (int'(in_col) < f2d_pkg::GRID_SIZE);
  assign out_free = !out_valid_r || !out_stall;

  assign er     = f2d_pkg::sat_ext({1'b0, erow_r} + (f2d_pkg::FLD_W + 1)'(1));
  assign ec     = f2d_pkg::sat_ext({1'b0, ecol_r} + (f2d_pkg::FLD_W + 1)'(1));
  assign sr     = f2d_pkg::sat_ext({1'b0, row_r});
  assign sc     = f2d_pkg::sat_ext({1'b0, col_r});
  assign quad_r = q_r[1] ? sr : er;
  assign quad_c = q_r[0] ? sc : ec;

  // end of inner and outer walk
  assign walk_down = (state_r == f2d_pkg::ST_SUM_WALK);
  assign col_end   = walk_down ? (c_step == '0) : (c_step > GRID_EXT);
  assign row_end   = walk_down ? (r_step == '0) : (r_step > GRID_EXT);

  f2d_step u_row_step (.x(r_r), .down(walk_down), .y(r_step));
  f2d_step u_col_step (.x(c_r), .down(walk_down), .y(c_step));
  f2d_alu  u_alu (.a(alu_a), .b(alu_b), .sub(alu_sub), .y(alu_y));

  f2d_ram #(.WIDTH(f2d_pkg::SUM_W), .DEPTH(f2d_pkg::CELLS)) u_tree_ram (
    .clk(clk), .addr(tree_addr), .we(tree_we), .wdata(tree_wdata), .rdata(tree_rdata)
  );

  f2d_ram #(.WIDTH(f2d_pkg::VAL_W), .DEPTH(f2d_pkg::CELLS)) u_cell_ram (
    .clk(clk), .addr(cell_addr), .we(cell_we), .wdata(cell_wdata), .rdata(cell_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      f2d_pkg::ST_CLEAR: begin
        if (clr_r == CLR_LAST) state_nxt = f2d_pkg::ST_IDLE;
      end
      f2d_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_op == f2d_pkg::OP_SUM) begin
            state_nxt = f2d_pkg::ST_SUM_LOAD;
          end else if (in_grid) begin
            state_nxt = f2d_pkg::ST_SET_CELL;
          end
        end
      end
      f2d_pkg::ST_SET_CELL: state_nxt = f2d_pkg::ST_SET_DIFF;
      f2d_pkg::ST_SET_DIFF: state_nxt = f2d_pkg::ST_SET_RD;
      f2d_pkg::ST_SET_RD:   state_nxt = f2d_pkg::ST_SET_WR;
      f2d_pkg::ST_SET_WR: begin
        state_nxt = (col_end && row_end) ? f2d_pkg::ST_IDLE : f2d_pkg::ST_SET_RD;
      end
      f2d_pkg::ST_SUM_LOAD: begin
        if (quad_r == '0 || quad_c == '0) begin
          state_nxt = (q_r == f2d_pkg::QUAD_LAST) ? f2d_pkg::ST_SUM_DONE
                                                   : f2d_pkg::ST_SUM_LOAD;
        end else begin
          state_nxt = f2d_pkg::ST_SUM_WALK;
        end
      end
      f2d_pkg::ST_SUM_WALK: begin
        if (col_end && row_end) begin
          state_nxt = (q_r == f2d_pkg::QUAD_LAST) ? f2d_pkg::ST_SUM_DONE
                                                   : f2d_pkg::ST_SUM_LOAD;
        end
      end
      f2d_pkg::ST_SUM_DONE: state_nxt = f2d_pkg::ST_SUM_OUT;
      f2d_pkg::ST_SUM_OUT: begin
        if (out_free) state_nxt = f2d_pkg::ST_IDLE;
      end
      default: state_nxt = f2d_pkg::ST_CLEAR;
    endcase
  end

  // memory and adder controls
  always_comb begin
    in_stall   = (state_r != f2d_pkg::ST_IDLE);
    tree_addr  = f2d_pkg::addr_of(r_r, c_r);
    cell_addr  = f2d_pkg::ADDR_W'(f2d_pkg::ADDR_W'(row_r) * f2d_pkg::ADDR_W'(f2d_pkg::GRID_SIZE))
                 + f2d_pkg::ADDR_W'(col_r);
    tree_we    = 1'b0;
    cell_we    = 1'b0;
    tree_wdata = alu_y;
    cell_wdata = nv_r;
    unique case (state_r)
      f2d_pkg::ST_CLEAR: begin
        tree_addr  = clr_r;
        cell_addr  = clr_r;
        tree_we    = 1'b1;
        cell_we    = 1'b1;
        tree_wdata = '0;
        cell_wdata = '0;
      end
      f2d_pkg::ST_SET_DIFF: cell_we = 1'b1;
      f2d_pkg::ST_SET_WR:   tree_we = 1'b1;
      default: ;
    endcase

    // adder: sum accumulate, cell difference, or node update
    priority if (pend_r) begin
      alu_a   = acc_r;
      alu_b   = tree_rdata;
      alu_sub = sign_r;
    end else if (state_r == f2d_pkg::ST_SET_DIFF) begin
      alu_a   = f2d_pkg::sext(nv_r);
      alu_b   = f2d_pkg::sext(cell_rdata);
      alu_sub = 1'b1;
    end else begin
      alu_a   = tree_rdata;
      alu_b   = diff_r;
      alu_sub = 1'b0;
    end
  end

  // datapath next values
  always_comb begin
    q_nxt         = q_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    c0_nxt        = c0_r;
    diff_nxt      = diff_r;
    acc_nxt       = pend_r ? alu_y : acc_r;
    pend_nxt      = (state_r == f2d_pkg::ST_SUM_WALK);
    sign_nxt      = q_r[1] ^ q_r[0];
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_sum_nxt   = out_sum_r;
    unique case (state_r)
      f2d_pkg::ST_CLEAR: clr_nxt = clr_r + f2d_pkg::ADDR_W'(1);
      f2d_pkg::ST_IDLE: begin
        q_nxt   = '0;
        acc_nxt = '0;
        r_nxt   = f2d_pkg::EXT_W'(in_row) + f2d_pkg::EXT_W'(1);
        c_nxt   = f2d_pkg::EXT_W'(in_col) + f2d_pkg::EXT_W'(1);
        c0_nxt  = f2d_pkg::EXT_W'(in_col) + f2d_pkg::EXT_W'(1);
      end
      f2d_pkg::ST_SET_DIFF: diff_nxt = alu_y;
      f2d_pkg::ST_SET_WR: begin
        if (col_end) begin
          r_nxt = f2d_pkg::EXT_W'(r_step);
          c_nxt = c0_r;
        end else begin
          c_nxt = f2d_pkg::EXT_W'(c_step);
        end
      end
      f2d_pkg::ST_SUM_LOAD: begin
        r_nxt  = quad_r;
        c_nxt  = quad_c;
        c0_nxt = quad_c;
        if (quad_r == '0 || quad_c == '0) q_nxt = q_r + 2'd1;
      end
      f2d_pkg::ST_SUM_WALK: begin
        if (col_end) begin
          r_nxt = f2d_pkg::EXT_W'(r_step);
          c_nxt = c0_r;
          if (row_end) q_nxt = q_r + 2'd1;
        end else begin
          c_nxt = f2d_pkg::EXT_W'(c_step);
        end
      end
      f2d_pkg::ST_SUM_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= f2d_pkg::ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r  <= in_row;
      col_r  <= in_col;
      erow_r <= in_end_row;
      ecol_r <= in_end_col;
      nv_r   <= in_new_value;
    end
    q_r       <= q_nxt;
    r_r       <= r_nxt;
    c_r       <= c_nxt;
    c0_r      <= c0_nxt;
    diff_r    <= diff_nxt;
    acc_r     <= acc_nxt;
    sign_r    <= sign_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_rect_sum = out_sum_r;

endmodule

FILE: hdl/f2d_ram.sv
module f2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/f2d_step.sv
module f2d_step (
  input  f2d_pkg::ext_t           x,
  input  logic                    down,
  output logic [f2d_pkg::EXT_W:0] y
);

  logic [f2d_pkg::EXT_W-1:0] low;

  // lowest set bit, then walk up (update path) or down (query path)
  assign low = x & (~x + f2d_pkg::EXT_W'(1));

  always_comb begin
    if (down) begin
      y = {1'b0, x - low};
    end else begin
      y = {1'b0, x} + {1'b0, low};
    end
  end

endmodule

FILE: hdl/f2d_alu.sv
module f2d_alu (
  input  f2d_pkg::sum_t a,
  input  f2d_pkg::sum_t b,
  input  logic          sub,
  output f2d_pkg::sum_t y
);

  // shared 52-bit add/subtract, wraps modulo 2^52
  always_comb begin
    if (sub) begin
      y = a - b;
    end else begin
      y = a + b;
    end
  end

endmodule
